// ===== hdl/tla_pkg.sv =====
// Shared types and constants for the telnet line assembler.
// No dependencies; imported by every module of the block.
`default_nettype none
package tla_pkg;

   localparam int LINE_CHARS_DEF = 62;
   // Line length and position width, sized for the largest supported line.
   localparam int POS_W = 6;
   localparam int QUEUE_DEPTH = 4;
   localparam logic [7:0] REPEAT_LIMIT_RST = 8'd20;

   localparam logic [7:0] BYTE_IAC  = 8'd255;
   localparam logic [7:0] BYTE_DONT = 8'd254;
   localparam logic [7:0] BYTE_DO   = 8'd253;
   localparam logic [7:0] BYTE_WILL = 8'd251;
   localparam logic [7:0] OPT_COMPRESS = 8'd86;
   localparam logic [7:0] BYTE_BS = 8'h08;
   localparam logic [7:0] BYTE_CR = 8'h0D;
   localparam logic [7:0] BYTE_LF = 8'h0A;
   localparam logic [7:0] BYTE_PRINT_LO = 8'h20;
   localparam logic [7:0] BYTE_PRINT_HI = 8'h7E;
   localparam logic [6:0] CHAR_SPACE = 7'h20;
   localparam logic [6:0] CHAR_BANG  = 7'h21;

   localparam logic [1:0] KIND_CHAR   = 2'd0;
   localparam logic [1:0] KIND_ZSTART = 2'd1;
   localparam logic [1:0] KIND_ZEND   = 2'd2;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_FINISH,
      OP_EVENT
   } op_kind_type;

   typedef struct packed {
      op_kind_type      kind;
      logic [POS_W-1:0] pos;
      logic [6:0]       data;
      logic             cut;
   } op_type;

endpackage
`default_nettype wire

// ===== hdl/telnet_line_assembler.sv =====
// Bytes are taken while the op queue has room; the queue decouples the front end
// from the line engine. At line end the engine compares the line with the last
// one when the lengths match, then emits it, each character via a registered
// memory read. Results leave through the queue and the output register, line
// characters also through the B_DECIDE, B_EMIT_RD and B_EMIT_OUT states.
// Synchronous active-high reset clears control state; line memories need none.
// Top level: joins tla_front, tla_queue and tla_back; depends on tla_pkg.
`default_nettype none
module telnet_line_assembler #(
   parameter int LINE_CHARS = tla_pkg::LINE_CHARS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic [7:0]   csr_wdata,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_rx_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [1:0]        rsp_kind,
   output logic [6:0]        rsp_text_char,
   output logic              rsp_last_of_line,
   output logic              rsp_too_long,
   output logic              rsp_repeat_warning
);
   import tla_pkg::*;

   op_type push_op, head_op;
   logic   push, full, pop, head_valid;

   tla_front #(.LINE_CHARS(LINE_CHARS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_rx_byte,
      .q_full(full), .q_push(push), .q_op(push_op)
   );

   tla_queue u_queue (
      .clock, .reset, .push, .push_op, .full, .pop, .head_valid, .head_op
   );

   tla_back #(.LINE_CHARS(LINE_CHARS)) u_back (
      .clock, .reset, .csr_we, .csr_wdata,
      .q_valid(head_valid), .q_op(head_op), .q_pop(pop),
      .rsp_valid, .rsp_ready, .rsp_kind, .rsp_text_char,
      .rsp_last_of_line, .rsp_too_long, .rsp_repeat_warning
   );

endmodule
`default_nettype wire

// ===== hdl/tla_front.sv =====
// Front end: telnet IAC filter and line length tracking; emits line ops.
// Depends on tla_pkg.
`default_nettype none
module tla_front #(
   parameter int LINE_CHARS = tla_pkg::LINE_CHARS_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic [7:0]      req_rx_byte,
   input  wire logic            q_full,
   output logic                 q_push,
   output tla_pkg::op_type      q_op
);
   import tla_pkg::*;

   typedef enum logic [1:0] {PH_IDLE, PH_IAC, PH_VERB} phase_type;
   typedef enum logic [1:0] {VERB_NONE, VERB_DO, VERB_DONT, VERB_WILL} verb_type;

   logic [POS_W-1:0] len_ff, len_in;
   phase_type        phase_ff, phase_in;
   verb_type         verb_ff, verb_in;
   logic             disc_ff, disc_in;
   logic             aft_ff, aft_in;
   logic             accept, term;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;
   assign term      = (req_rx_byte == BYTE_CR) || (req_rx_byte == BYTE_LF);

   always_comb begin
      len_in   = len_ff;
      phase_in = phase_ff;
      verb_in  = verb_ff;
      disc_in  = disc_ff;
      aft_in   = aft_ff;
      q_push   = 1'b0;
      q_op.kind = OP_WRITE;
      q_op.pos  = len_ff;
      q_op.data = req_rx_byte[6:0];
      q_op.cut  = 1'b0;
      if (accept) begin
         if (disc_ff) begin
            if (term) begin
               disc_in = 1'b0;
               aft_in  = 1'b1;
            end
         end else if (term) begin
            if (!aft_ff) begin
               aft_in    = 1'b1;
               q_push    = 1'b1;
               q_op.kind = OP_FINISH;
               len_in    = '0;
               phase_in  = PH_IDLE;
               verb_in   = VERB_NONE;
            end
         end else begin
            aft_in = 1'b0;
            if (len_ff >= POS_W'(LINE_CHARS)) begin
               // cut the line, drop through the next terminator
               disc_in   = 1'b1;
               q_push    = 1'b1;
               q_op.kind = OP_FINISH;
               q_op.cut  = 1'b1;
               len_in    = '0;
               phase_in  = PH_IDLE;
               verb_in   = VERB_NONE;
            end else if (req_rx_byte == BYTE_IAC) begin
               phase_in = PH_IAC;
            end else if (phase_ff == PH_IAC && (req_rx_byte == BYTE_DO ||
                         req_rx_byte == BYTE_DONT || req_rx_byte == BYTE_WILL)) begin
               phase_in = PH_VERB;
               verb_in  = (req_rx_byte == BYTE_DO) ? VERB_DO :
                          (req_rx_byte == BYTE_DONT) ? VERB_DONT : VERB_WILL;
            end else if (phase_ff == PH_VERB) begin
               phase_in = PH_IDLE;
               verb_in  = VERB_NONE;
               if (req_rx_byte == OPT_COMPRESS &&
                   (verb_ff == VERB_DO || verb_ff == VERB_DONT)) begin
                  q_push    = 1'b1;
                  q_op.kind = OP_EVENT;
                  q_op.data = {5'd0, (verb_ff == VERB_DO) ? KIND_ZSTART : KIND_ZEND};
               end
            end else if (req_rx_byte == BYTE_BS && len_ff != '0) begin
               len_in = len_ff - 1'b1;
            end else if (req_rx_byte >= BYTE_PRINT_LO && req_rx_byte <= BYTE_PRINT_HI) begin
               q_push = 1'b1;
               len_in = len_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         phase_ff <= PH_IDLE;
         verb_ff  <= VERB_NONE;
         disc_ff  <= 1'b0;
         aft_ff   <= 1'b0;
      end else begin
         len_ff   <= len_in;
         phase_ff <= phase_in;
         verb_ff  <= verb_in;
         disc_ff  <= disc_in;
         aft_ff   <= aft_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/tla_queue.sv =====
// Small op queue between the front end and the line engine.
// Depends on tla_pkg.
`default_nettype none
module tla_queue (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  tla_pkg::op_type   push_op,
   output logic              full,
   input  wire logic         pop,
   output logic              head_valid,
   output tla_pkg::op_type   head_op
);
   import tla_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   op_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]     count_ff;

   assign full       = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
      end
   end

endmodule
`default_nettype wire

// ===== hdl/tla_back.sv =====
// Line engine: line and history memories, repeat check, line emission.
// Depends on tla_pkg.
`default_nettype none
module tla_back #(
   parameter int LINE_CHARS = tla_pkg::LINE_CHARS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic [7:0]   csr_wdata,
   input  wire logic         q_valid,
   input  tla_pkg::op_type   q_op,
   output logic              q_pop,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [1:0]        rsp_kind,
   output logic [6:0]        rsp_text_char,
   output logic              rsp_last_of_line,
   output logic              rsp_too_long,
   output logic              rsp_repeat_warning
);
   import tla_pkg::*;

   localparam int IDX_W = $clog2(LINE_CHARS);

   typedef enum logic [2:0] {
      B_IDLE, B_CMP_RD, B_CMP_CHK, B_DECIDE, B_EMIT_RD, B_EMIT_OUT
   } state_type;

   logic [6:0] line_mem [LINE_CHARS];
   logic [6:0] prev_mem [LINE_CHARS];
   logic [6:0] line_q_ff, prev_q_ff;
   logic             st_we, pv_we;
   logic [IDX_W-1:0] st_waddr, rd_addr;
   logic [6:0]       st_wdata, pv_wdata;

   state_type        state_ff, state_in;
   logic [POS_W-1:0] idx_ff, idx_in, len_ff, len_in, emit_len_ff, emit_len_in;
   logic [POS_W-1:0] prev_len_ff, prev_len_in;
   logic             cut_ff, cut_in, bang_ff, bang_in, counted_ff, counted_in;
   logic             same_ff, same_in, warn_ff, warn_in, from_prev_ff, from_prev_in;
   logic [6:0]       first_ff, first_in;
   logic [7:0]       rcount_ff, rcount_in, limit_ff, limit_in;
   logic             rv_ff, rv_in, last_ff, last_in, tl_ff, tl_in, rw_ff, rw_in;
   logic [1:0]       kind_ff, kind_in;
   logic [6:0]       ch_ff, ch_in;

   logic             out_free, is_last;
   logic [POS_W-1:0] eff_len;
   logic [6:0]       eff_first, emit_ch;
   logic [7:0]       rc_next;

   assign rd_addr  = idx_ff[IDX_W-1:0];
   assign out_free = !rv_ff || rsp_ready;
   assign eff_len  = (q_op.pos == '0) ? POS_W'(1) : q_op.pos;
   assign eff_first = (q_op.pos == '0) ? CHAR_SPACE : first_ff;
   assign emit_ch  = from_prev_ff ? prev_q_ff : line_q_ff;
   assign is_last  = (idx_ff + 1'b1 == emit_len_ff);
   assign rc_next  = (rcount_ff == 8'd255) ? rcount_ff : rcount_ff + 8'd1;

   assign rsp_valid          = rv_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_text_char      = ch_ff;
   assign rsp_last_of_line   = last_ff;
   assign rsp_too_long       = tl_ff;
   assign rsp_repeat_warning = rw_ff;

   always_comb begin
      state_in = state_ff;   idx_in = idx_ff;        len_in = len_ff;
      emit_len_in = emit_len_ff;  prev_len_in = prev_len_ff;
      cut_in = cut_ff;  bang_in = bang_ff;  counted_in = counted_ff;
      same_in = same_ff;  warn_in = warn_ff;  from_prev_in = from_prev_ff;
      first_in = first_ff;  rcount_in = rcount_ff;
      limit_in = csr_we ? csr_wdata : limit_ff;
      rv_in = rv_ff;  last_in = last_ff;  tl_in = tl_ff;  rw_in = rw_ff;
      kind_in = kind_ff;  ch_in = ch_ff;
      q_pop = 1'b0;
      st_we = 1'b0;  st_waddr = q_op.pos[IDX_W-1:0];  st_wdata = q_op.data;
      pv_we = 1'b0;  pv_wdata = emit_ch;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               case (q_op.kind)
                  OP_WRITE: begin
                     q_pop = 1'b1;
                     st_we = 1'b1;
                     if (q_op.pos == '0) first_in = q_op.data;
                  end
                  OP_EVENT: begin
                     if (out_free) begin
                        q_pop = 1'b1;
                        rv_in = 1'b1;  kind_in = q_op.data[1:0];  ch_in = '0;
                        last_in = 1'b0;  tl_in = 1'b0;  rw_in = 1'b0;
                     end
                  end
                  OP_FINISH: begin
                     q_pop  = 1'b1;
                     cut_in = q_op.cut;
                     len_in = eff_len;
                     idx_in = '0;
                     same_in = 1'b0;
                     bang_in = (eff_first == CHAR_BANG);
                     counted_in = (eff_len > POS_W'(1)) || (eff_first == CHAR_BANG);
                     if (q_op.pos == '0) begin
                        // empty line becomes a single space
                        st_we = 1'b1;  st_waddr = '0;  st_wdata = CHAR_SPACE;
                        first_in = CHAR_SPACE;
                     end
                     if (eff_len > POS_W'(1) && eff_first != CHAR_BANG &&
                         eff_len == prev_len_ff) begin
                        state_in = B_CMP_RD;
                     end else begin
                        state_in = B_DECIDE;
                     end
                  end
                  default: q_pop = 1'b1;
               endcase
            end
         end
         B_CMP_RD: state_in = B_CMP_CHK;
         B_CMP_CHK: begin
            if (line_q_ff != prev_q_ff) begin
               state_in = B_DECIDE;
            end else if (idx_ff + 1'b1 == len_ff) begin
               same_in  = 1'b1;
               state_in = B_DECIDE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = B_CMP_RD;
            end
         end
         B_DECIDE: begin
            warn_in = 1'b0;
            idx_in  = '0;
            if (counted_ff) begin
               if (!bang_ff && !same_ff) begin
                  rcount_in = '0;
               end else begin
                  rcount_in = rc_next;
                  warn_in   = (rc_next >= limit_ff);
               end
            end
            if (bang_ff) begin
               from_prev_in = 1'b1;
               emit_len_in  = prev_len_ff;
               state_in     = (prev_len_ff == '0) ? B_IDLE : B_EMIT_RD;
            end else begin
               from_prev_in = 1'b0;
               emit_len_in  = len_ff;
               prev_len_in  = len_ff;
               state_in     = B_EMIT_RD;
            end
         end
         B_EMIT_RD: state_in = B_EMIT_OUT;
         B_EMIT_OUT: begin
            if (out_free) begin
               rv_in = 1'b1;  kind_in = KIND_CHAR;  ch_in = emit_ch;
               last_in = is_last;  tl_in = cut_ff;  rw_in = warn_ff;
               // copy the new line into history as it goes out
               pv_we = !from_prev_ff;
               if (is_last) begin
                  state_in = B_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = B_EMIT_RD;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_we) line_mem[st_waddr] <= st_wdata;
      line_q_ff <= line_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (pv_we) prev_mem[rd_addr] <= pv_wdata;
      prev_q_ff <= prev_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         prev_len_ff <= '0;
         rcount_ff <= '0;
         limit_ff <= REPEAT_LIMIT_RST;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         prev_len_ff <= prev_len_in;
         rcount_ff <= rcount_in;
         limit_ff <= limit_in;
         rv_ff <= rv_in;
      end
      idx_ff <= idx_in;  len_ff <= len_in;  emit_len_ff <= emit_len_in;
      cut_ff <= cut_in;  bang_ff <= bang_in;  counted_ff <= counted_in;
      same_ff <= same_in;  warn_ff <= warn_in;  from_prev_ff <= from_prev_in;
      first_ff <= first_in;
      last_ff <= last_in;  tl_ff <= tl_in;  rw_ff <= rw_in;
      kind_ff <= kind_in;  ch_ff <= ch_in;
   end

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for telnet_line_assembler: byte items in, line characters and events out.
// Predicts every result in SystemVerilog and compares each one whole; needs tla_pkg and the RTL.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tla_pkg::*;

   localparam int LINE_MAX = LINE_CHARS_DEF;

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] text_char;
      logic       last_of_line;
      logic       too_long;
      logic       repeat_warning;
   } line_result_type;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [7:0] csr_wdata;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_kind;
   logic [6:0] rsp_text_char;
   logic       rsp_last_of_line;
   logic       rsp_too_long;
   logic       rsp_repeat_warning;

   telnet_line_assembler u_top (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_text_char(rsp_text_char), .rsp_last_of_line(rsp_last_of_line),
      .rsp_too_long(rsp_too_long), .rsp_repeat_warning(rsp_repeat_warning)
   );

   // predicted block state
   logic [6:0] cur_line [LINE_MAX];
   logic [6:0] prev_line [LINE_MAX];
   int         cur_len;
   int         prev_len;
   logic [7:0] repeat_cnt;
   logic [7:0] repeat_limit;
   int         iac_state;
   int         neg_verb;
   logic       dropping;
   logic       after_term;

   line_result_type expected_results[$];
   int errors;
   int bytes_sent;
   int results_seen;
   int tx_idle_pct;
   int rx_idle_pct;
   int rx_hold_len;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("timeout at %0t", $time);
      $display("tb_top failed");
      $finish;
   end

   task automatic push_result(input logic [1:0] k, input logic [6:0] ch, input logic last,
                              input logic tl, input logic rw);
      line_result_type r;
      r.kind = k;
      r.text_char = ch;
      r.last_of_line = last;
      r.too_long = tl;
      r.repeat_warning = rw;
      expected_results.push_back(r);
   endtask

   task automatic close_line(input logic cut);
      int  n;
      logic warn;
      logic bang;
      logic same;
      n = cur_len;
      warn = 1'b0;
      if (n == 0) begin
         cur_line[0] = CHAR_SPACE;
         n = 1;
      end
      bang = (cur_line[0] == CHAR_BANG);
      if (n > 1 || bang) begin
         same = (n == prev_len);
         for (int i = 0; i < n && same; i++) begin
            if (cur_line[i] != prev_line[i]) same = 1'b0;
         end
         if (!bang && !same) begin
            repeat_cnt = 8'd0;
         end else begin
            if (repeat_cnt != 8'd255) repeat_cnt++;
            if (repeat_cnt >= repeat_limit) warn = 1'b1;
         end
      end
      if (bang) begin
         n = prev_len;
         for (int i = 0; i < n; i++) cur_line[i] = prev_line[i];
      end else begin
         for (int i = 0; i < n; i++) prev_line[i] = cur_line[i];
         prev_len = n;
      end
      for (int i = 0; i < n; i++) begin
         push_result(KIND_CHAR, cur_line[i], (i + 1 == n), cut, warn);
      end
      cur_len = 0;
      iac_state = 0;
      neg_verb = 0;
   endtask

   task automatic predict_byte(input logic [7:0] b);
      logic term;
      int   verb;
      term = (b == BYTE_CR || b == BYTE_LF);
      if (dropping) begin
         if (term) begin
            dropping = 1'b0;
            after_term = 1'b1;
         end
      end else if (term) begin
         if (!after_term) begin
            after_term = 1'b1;
            close_line(1'b0);
         end
      end else begin
         after_term = 1'b0;
         if (cur_len >= LINE_MAX) begin
            dropping = 1'b1;
            close_line(1'b1);
         end else if (b == BYTE_IAC) begin
            iac_state = 1;
         end else if (iac_state == 1 && (b == BYTE_DO || b == BYTE_DONT || b == BYTE_WILL)) begin
            iac_state = 2;
            neg_verb = (b == BYTE_DO) ? 1 : (b == BYTE_DONT) ? 2 : 3;
         end else if (iac_state == 2) begin
            verb = neg_verb;
            iac_state = 0;
            neg_verb = 0;
            if (b == OPT_COMPRESS && verb == 1) begin
               push_result(KIND_ZSTART, 7'd0, 1'b0, 1'b0, 1'b0);
            end
            if (b == OPT_COMPRESS && verb == 2) begin
               push_result(KIND_ZEND, 7'd0, 1'b0, 1'b0, 1'b0);
            end
         end else if (b == BYTE_BS && cur_len > 0) begin
            cur_len--;
         end else if (b >= BYTE_PRINT_LO && b <= BYTE_PRINT_HI) begin
            cur_line[cur_len] = b[6:0];
            cur_len++;
         end
      end
   endtask

   // Present one item and hold it until accepted; valid may drop at random between items.
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      predict_byte(b);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // Drop valid, drain all results and let any work in flight settle.
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic write_limit(input logic [7:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      repeat_limit = v;
   endtask

   function automatic logic [7:0] rand_print();
      return 8'($urandom_range(BYTE_PRINT_LO, BYTE_PRINT_HI));
   endfunction

   // receiver: random stalls plus a counted long hold-off
   always @(negedge clock) begin
      if (rx_hold_len > 0) begin
         rx_hold_len <= rx_hold_len - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      line_result_type got;
      line_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_kind, rsp_text_char, rsp_last_of_line, rsp_too_long, rsp_repeat_warning};
         results_seen++;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result kind=%0d char=%h last=%b cut=%b warn=%b", $time,
                     got.kind, got.text_char, got.last_of_line, got.too_long,
                     got.repeat_warning);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected kind=%0d char=%h last=%b cut=%b warn=%b",
                        $time, want.kind, want.text_char, want.last_of_line, want.too_long,
                        want.repeat_warning);
               $display("%0t:          actual   kind=%0d char=%h last=%b cut=%b warn=%b",
                        $time, got.kind, got.text_char, got.last_of_line, got.too_long,
                        got.repeat_warning);
               errors++;
            end
         end
      end
   end

   task automatic test_directed;
      send_text("!\r");                // bang with nothing to repeat
      send_text("ab\r\n");             // second terminator skipped
      send_text("!\r");
      send_byte(8'h78);
      send_byte(BYTE_BS);
      send_byte(BYTE_BS);              // backspace on empty line
      send_byte(BYTE_CR);              // empty line becomes a space
      send_byte(BYTE_IAC); send_byte(BYTE_DO); send_byte(OPT_COMPRESS);
      send_byte(BYTE_IAC); send_byte(BYTE_DONT); send_byte(OPT_COMPRESS);
      send_byte(BYTE_IAC); send_byte(BYTE_IAC); send_byte(BYTE_WILL); send_byte(OPT_COMPRESS);
      send_byte(BYTE_IAC); send_byte(8'h71); send_byte(BYTE_DO); send_byte(BYTE_CR);
      send_byte(8'h00); send_byte(8'h7F); send_byte(8'h80); send_byte(BYTE_LF);
   endtask

   task automatic test_line_limit;
      for (int i = 0; i < LINE_MAX; i++) send_byte(rand_print());
      send_byte(rand_print());         // one past the limit cuts the line
      send_byte(BYTE_IAC); send_byte(BYTE_DO); send_byte(OPT_COMPRESS);  // dropped
      send_byte(BYTE_CR);
      send_byte(BYTE_LF);              // skipped after discard ends
   endtask

   task automatic test_repeats(input logic [7:0] lim);
      write_limit(lim);
      for (int i = 0; i < 2; i++) send_text("ab\r");
      send_text("!\r");
      send_text("z\r");
   endtask

   task automatic test_backpressure;
      drain();
      rx_hold_len = 200;
      send_text("abc\r");
      send_text("defghij\r");
   endtask

   task automatic test_random(input int n_items);
      int sent;
      int len;
      int r;
      logic [7:0] stash [$];
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(99);
         if (r < 15) begin
            send_byte(8'($urandom_range(0, 255)));
            sent++;
         end else if (r < 25) begin
            send_byte(BYTE_IAC);
            send_byte($urandom_range(1) ? BYTE_DO : ($urandom_range(1) ? BYTE_DONT : BYTE_WILL));
            send_byte($urandom_range(2) ? OPT_COMPRESS : 8'($urandom_range(0, 255)));
            sent += 3;
         end else if (r < 40 && stash.size() > 0) begin
            foreach (stash[i]) send_byte(stash[i]);
            send_byte(BYTE_CR);
            sent += stash.size() + 1;
         end else begin
            len = ($urandom_range(19) == 0) ? $urandom_range(55, 66) : $urandom_range(0, 8);
            stash.delete();
            if ($urandom_range(9) == 0) stash.push_back(8'h21);
            for (int i = 0; i < len; i++) begin
               stash.push_back(($urandom_range(9) == 0) ? BYTE_BS : rand_print());
            end
            foreach (stash[i]) send_byte(stash[i]);
            send_byte($urandom_range(1) ? BYTE_CR : BYTE_LF);
            sent += stash.size() + 1;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = 8'd0;
      req_valid = 1'b0;
      req_rx_byte = 8'd0;
      rsp_ready = 1'b0;
      errors = 0;
      bytes_sent = 0;
      results_seen = 0;
      tx_idle_pct = 32;
      rx_idle_pct = 32;
      rx_hold_len = 0;
      cur_len = 0;
      prev_len = 0;
      repeat_cnt = 8'd0;
      repeat_limit = REPEAT_LIMIT_RST;
      iac_state = 0;
      neg_verb = 0;
      dropping = 1'b0;
      after_term = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_line_limit();
      test_repeats(8'd0);
      test_repeats(8'd2);
      test_backpressure();
      // stretch without idling on either side
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_random(20);
      drain();

      $display("covered %0d items and %0d results: IAC filtering, line cut, repeats",
               bytes_sent, results_seen);
      $display("repeat limits 0, 2 and 20, with a long receiver hold-off");
      if (errors == 0 && expected_results.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
